[rtl/amsc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// amsc_pkg
// Shared widths, register indexes, reset values and codes for the
// accelerometer magnitude step counter.
// ============================================================================
package amsc_pkg;

    localparam int DATA_W          = 16;
    localparam int SUM_W           = 2 * DATA_W;
    localparam int CFG_IDX_W       = 2;
    localparam int ROOT_ITERS      = DATA_W;
    localparam int ITER_W          = $clog2(ROOT_ITERS);
    localparam int COUNT_WIDTH_DEF = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_TICKS  = 2'd2;

    // 0.25 g and 3.0 g over 3.9 mg/LSB, truncated
    localparam logic [DATA_W-1:0] LOW_THRESHOLD_RST  = 16'd64;
    localparam logic [DATA_W-1:0] HIGH_THRESHOLD_RST = 16'd769;
    localparam logic [DATA_W-1:0] LOCKOUT_TICKS_RST  = 16'd200;

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // first root bit: (1 << (SUM_W - 2))
    localparam logic [SUM_W-1:0] ROOT_BIT_INIT = SUM_W'(1) << (SUM_W - 2);

endpackage

[rtl/accel_magnitude_step_counter_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// accel_magnitude_step_counter_top
// Step counter: magnitude of an X/Y sample, delta against the previous
// magnitude, window test, saturating count and a tick-driven lockout.
// ============================================================================
// Sequence: a sample word goes from accept through the squaring states
//   ST_SQX and ST_SQY on the shared multiplier, 16 root iterations and the
//   decide state ST_FINISH before out_valid; a tick word goes straight to ST_FINISH.
// A new word is accepted only in ST_IDLE, so a word is taken only after the
//   previous one has loaded the result register, which a stall can delay.
// Reset: rst_n is asynchronous, active low; thresholds return to 64 / 769,
//   lockout to 200 ticks, step count, last magnitude and lockout counter to 0.
module accel_magnitude_step_counter_top
#(
    parameter int COUNT_WIDTH = amsc_pkg::COUNT_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    // input words
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            operation,
    input  logic signed [amsc_pkg::DATA_W-1:0] accel_x,
    input  logic signed [amsc_pkg::DATA_W-1:0] accel_y,

    // result words
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            step_seen,
    output logic                            sample_ignored,
    output logic [amsc_pkg::DATA_W-1:0]     magnitude,
    output logic [amsc_pkg::DATA_W-1:0]     total_steps,

    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [amsc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [amsc_pkg::DATA_W-1:0]     cfg_data
);

    import amsc_pkg::*;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,   // waiting for a word
        ST_SQX    = 5'b00010,   // ax * ax into the accumulator
        ST_SQY    = 5'b00100,   // accumulator += ay * ay
        ST_ROOT   = 5'b01000,   // one root bit per cycle
        ST_FINISH = 5'b10000    // window test, state update, load output
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [DATA_W-1:0] low_thr_reg;
    logic [DATA_W-1:0] high_thr_reg;
    logic [DATA_W-1:0] lockout_ticks_reg;

    // block state
    logic [DATA_W-1:0]      last_mag_reg;
    logic [COUNT_WIDTH-1:0] steps_reg;
    logic [DATA_W-1:0]      lockout_left_reg;

    // captured word
    logic              op_reg;
    logic [DATA_W-1:0] ax_reg;
    logic [DATA_W-1:0] ay_reg;

    // shared arithmetic datapath
    logic [SUM_W-1:0]  rem_reg;     // radicand, then running remainder
    logic [SUM_W-1:0]  root_reg;
    logic [SUM_W-1:0]  bit_reg;
    logic [ITER_W-1:0] iter_reg;

    // output register
    logic              out_valid_reg;
    logic              step_seen_reg;
    logic              ignored_reg;
    logic [DATA_W-1:0] mag_out_reg;
    logic [DATA_W-1:0] total_reg;

    logic              in_fire;
    logic              out_free;
    logic [DATA_W-1:0] abs_x;
    logic [DATA_W-1:0] abs_y;
    logic [DATA_W-1:0] mul_opnd;
    logic [SUM_W-1:0]  mul_prod;
    logic [SUM_W-1:0]  trial;
    logic              trial_ok;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] diff;
    logic              in_window;
    logic [COUNT_WIDTH-1:0] steps_inc;
    logic [SUM_W-1:0]  steps_wide;
    logic [SUM_W-1:0]  steps_inc_wide;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // two's complement magnitude; -32768 maps to 32768 unsigned
    assign abs_x = accel_x[DATA_W-1] ? DATA_W'(-accel_x) : DATA_W'(accel_x);
    assign abs_y = accel_y[DATA_W-1] ? DATA_W'(-accel_y) : DATA_W'(accel_y);

    // one multiplier, shared by both squares
    assign mul_opnd = (state_reg == ST_SQX) ? ax_reg : ay_reg;
    assign mul_prod = SUM_W'(mul_opnd) * SUM_W'(mul_opnd);

    // root digit: compare and subtract
    assign trial    = root_reg + bit_reg;
    assign trial_ok = (rem_reg >= trial);

    // decide-cycle logic; root fits in 16 bits after the last iteration
    assign mag       = root_reg[DATA_W-1:0];
    assign diff      = (mag >= last_mag_reg) ? (mag - last_mag_reg) : (last_mag_reg - mag);
    assign in_window = (diff > low_thr_reg) && (diff < high_thr_reg);
    assign steps_inc = (&steps_reg) ? steps_reg : (steps_reg + COUNT_WIDTH'(1));
    assign steps_wide = SUM_W'(steps_reg);
    assign steps_inc_wide = SUM_W'(steps_inc);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (operation == OP_TICK) ? ST_FINISH : ST_SQX;
                end
            end
            ST_SQX:    state_next = ST_SQY;
            ST_SQY:    state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (iter_reg == ITER_W'(ROOT_ITERS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // configuration registers; always ready, a write lands at its edge
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg       <= LOW_THRESHOLD_RST;
            high_thr_reg      <= HIGH_THRESHOLD_RST;
            lockout_ticks_reg <= LOCKOUT_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOW_THRESHOLD:  low_thr_reg       <= cfg_data;
                CFG_HIGH_THRESHOLD: high_thr_reg      <= cfg_data;
                CFG_LOCKOUT_TICKS:  lockout_ticks_reg <= cfg_data;
                default:            ; // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // word capture and shared multiply / root datapath (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= operation;
            ax_reg   <= abs_x;
            ay_reg   <= abs_y;
            root_reg <= '0;
            bit_reg  <= ROOT_BIT_INIT;
            iter_reg <= '0;
        end
        case (state_reg)
            ST_SQX:
            begin
                rem_reg <= mul_prod;
            end
            ST_SQY:
            begin
                // sum of squares peaks at 2^31, no carry out of 32 bits
                rem_reg <= rem_reg + mul_prod;
            end
            ST_ROOT:
            begin
                if (trial_ok)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg  <= bit_reg >> 2;
                iter_reg <= iter_reg + ITER_W'(1);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // block state update and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_mag_reg     <= '0;
            steps_reg        <= '0;
            lockout_left_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg == OP_TICK)
                begin
                    if (lockout_left_reg != '0)
                    begin
                        lockout_left_reg <= lockout_left_reg - DATA_W'(1);
                    end
                end
                else if (lockout_left_reg == '0)
                begin
                    last_mag_reg <= mag;
                    if (in_window)
                    begin
                        steps_reg        <= steps_inc;
                        lockout_left_reg <= lockout_ticks_reg;
                    end
                end
            end
        end
    end

    // payload half of the output register
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            if (op_reg == OP_TICK)
            begin
                step_seen_reg <= 1'b0;
                ignored_reg   <= 1'b0;
                mag_out_reg   <= '0;
                total_reg     <= steps_wide[DATA_W-1:0];
            end
            else if (lockout_left_reg != '0)
            begin
                // dropped sample still reports its root
                step_seen_reg <= 1'b0;
                ignored_reg   <= 1'b1;
                mag_out_reg   <= mag;
                total_reg     <= steps_wide[DATA_W-1:0];
            end
            else
            begin
                step_seen_reg <= in_window;
                ignored_reg   <= 1'b0;
                mag_out_reg   <= mag;
                if (in_window)
                begin
                    total_reg <= steps_inc_wide[DATA_W-1:0];
                end
                else
                begin
                    total_reg <= steps_wide[DATA_W-1:0];
                end
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign step_seen      = step_seen_reg;
    assign sample_ignored = ignored_reg;
    assign magnitude      = mag_out_reg;
    assign total_steps    = total_reg;

endmodule

[rtl/amsc_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// amsc_checker
// Port-level checks for the step counter, bound to the top level.
// ============================================================================
module amsc_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            operation,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            step_seen,
    input  logic                            sample_ignored,
    input  logic [amsc_pkg::DATA_W-1:0]     magnitude,
    input  logic [amsc_pkg::DATA_W-1:0]     total_steps
);

    import amsc_pkg::*;

    // one word in flight: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready stayed high after a word was accepted");

    // a tick taken with the result register free never reports a step,
    // a drop or a magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (operation == OP_TICK) && (!out_valid || out_ready))
        |-> ##2
        (out_valid && !step_seen && !sample_ignored && (magnitude == '0)))
        else $error("tick result carries sample fields");

    // a counted step and a dropped sample exclude each other
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(step_seen && sample_ignored))
        else $error("step_seen and sample_ignored both set");

    // stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(magnitude) && $stable(total_steps)))
        else $error("result word changed while stalled");

endmodule

bind accel_magnitude_step_counter_top amsc_checker u_amsc_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .step_seen      (step_seen),
    .sample_ignored (sample_ignored),
    .magnitude      (magnitude),
    .total_steps    (total_steps)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for accel_magnitude_step_counter_top. A scoreboard
// class predicts every result word from the accepted input words and the
// register writes. Random gaps and stalls are applied on both channels,
// including one long output stall that backs the block up into its input.
// ============================================================================
module testbench;
    import amsc_pkg::*;

    // Step count as the block is built by default.
    localparam int STEP_COUNT_W = COUNT_WIDTH_DEF;
    localparam int COUNT_MAX    = (1 << STEP_COUNT_W) - 1;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // Receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_AFTER_RESULTS = 150;
    localparam int HOLD_CYCLES        = 400;

    typedef struct packed {
        logic              seen;
        logic              dropped;
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] count;
    } step_report_t;

    // ------------------------------------------------------------------------
    // Scoreboard: its own copy of registers and step state, plus the queue of
    // result words still owed by the block.
    // ------------------------------------------------------------------------
    class step_count_board;
        logic [DATA_W-1:0] low_limit;
        logic [DATA_W-1:0] high_limit;
        logic [DATA_W-1:0] lockout_len;
        logic [DATA_W-1:0] prev_mag;
        logic [DATA_W-1:0] lockout_left;
        int                step_total;
        step_report_t      pending[$];
        int mismatches, n_samples, n_ticks, n_steps, n_dropped, n_saturated;

        function new();
            low_limit    = LOW_THRESHOLD_RST;
            high_limit   = HIGH_THRESHOLD_RST;
            lockout_len  = LOCKOUT_TICKS_RST;
            prev_mag     = '0;
            lockout_left = '0;
            step_total   = 0;
            mismatches   = 0;
            n_samples    = 0;
            n_ticks      = 0;
            n_steps      = 0;
            n_dropped    = 0;
            n_saturated  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            case (idx)
                CFG_LOW_THRESHOLD:  low_limit   = val;
                CFG_HIGH_THRESHOLD: high_limit  = val;
                CFG_LOCKOUT_TICKS:  lockout_len = val;
                default: ;
            endcase
        endfunction

        // exact floor root, one result bit at a time
        function logic [DATA_W-1:0] root_of(longint n);
            longint r;
            longint c;
            r = 0;
            for (int b = DATA_W - 1; b >= 0; b--) begin
                c = r + (longint'(1) << b);
                if (c * c <= n)
                    r = c;
            end
            return DATA_W'(r);
        endfunction

        function void note_input(logic op, logic signed [DATA_W-1:0] x,
                                 logic signed [DATA_W-1:0] y);
            step_report_t r;
            int ax;
            int ay;
            int delta;
            r = '0;
            if (op == OP_TICK) begin
                n_ticks++;
                if (lockout_left != 0)
                    lockout_left--;
            end
            else begin
                n_samples++;
                ax = (x < 0) ? -int'(x) : int'(x);
                ay = (y < 0) ? -int'(y) : int'(y);
                r.mag = root_of(longint'(ax) * ax + longint'(ay) * ay);
                if (lockout_left != 0) begin
                    r.dropped = 1'b1;
                    n_dropped++;
                end
                else begin
                    delta = int'(r.mag) - int'(prev_mag);
                    if (delta < 0)
                        delta = -delta;
                    if (delta > int'(low_limit) && delta < int'(high_limit)) begin
                        r.seen = 1'b1;
                        n_steps++;
                        if (step_total < COUNT_MAX)
                            step_total++;
                        else
                            n_saturated++;
                        lockout_left = lockout_len;
                    end
                    prev_mag = r.mag;
                end
            end
            r.count = DATA_W'(step_total);
            pending.push_back(r);
        endfunction

        function void check_result(step_report_t got);
            step_report_t want;
            if (pending.size() == 0) begin
                $error("result word with nothing outstanding");
                mismatches++;
                return;
            end
            want = pending.pop_front();
            if (got.seen !== want.seen) begin
                $error("step_seen: expected %0d, got %0d", want.seen, got.seen);
                mismatches++;
            end
            if (got.dropped !== want.dropped) begin
                $error("sample_ignored: expected %0d, got %0d", want.dropped, got.dropped);
                mismatches++;
            end
            if (got.mag !== want.mag) begin
                $error("magnitude: expected %0d, got %0d", want.mag, got.mag);
                mismatches++;
            end
            if (got.count !== want.count) begin
                $error("total_steps: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     operation = OP_SAMPLE;
    logic signed [DATA_W-1:0] accel_x = '0;
    logic signed [DATA_W-1:0] accel_y = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     step_seen;
    logic                     sample_ignored;
    logic [DATA_W-1:0]        magnitude;
    logic [DATA_W-1:0]        total_steps;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [DATA_W-1:0]        cfg_data = '0;

    step_count_board board;
    int              send_calm = 0;

    accel_magnitude_step_counter_top #(
        .COUNT_WIDTH (STEP_COUNT_W)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .accel_x        (accel_x),
        .accel_y        (accel_y),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .step_seen      (step_seen),
        .sample_ignored (sample_ignored),
        .magnitude      (magnitude),
        .total_steps    (total_steps),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop well past the slowest legal run (~1200 words at worst-case
    // gaps and stalls).
    initial
    begin
        #2000000;
        $display("accel_magnitude_step_counter_top test failed");
        $finish;
    end

    // Gap length: mostly zero or short, now and then long, with runs of
    // back-to-back words in between.
    function automatic int pick_gap(ref int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3)
            calm_left = $urandom_range(40, 15);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Handshakes are sampled on the falling edge, where every
    // signal has settled; the word is taken at the following rising edge.
    // in_valid is lowered only when a gap actually starts.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic op, input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y);
        int gap;
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        accel_x   <= x;
        accel_y   <= y;
        do @(negedge clk); while (!in_ready);
        board.note_input(op, x, y);
        @(posedge clk);
    endtask

    // Axis-aligned sample whose magnitude sits a chosen distance from the
    // previous one: on either threshold, just inside, or anywhere in the window.
    function automatic void aim_sample(output logic signed [DATA_W-1:0] x,
                                       output logic signed [DATA_W-1:0] y);
        int lo;
        int hi;
        int d;
        int target;
        lo = board.low_limit;
        hi = board.high_limit;
        case ($urandom_range(4))
            0: d = lo;
            1: d = lo + 1;
            2: d = hi - 1;
            3: d = hi;
            default: d = (hi > lo + 1) ? $urandom_range(hi - 1, lo + 1)
                                       : $urandom_range(2000);
        endcase
        if (d < 0)
            d = 0;
        target = $urandom_range(1) ? int'(board.prev_mag) + d : int'(board.prev_mag) - d;
        if (target < 0)
            target = int'(board.prev_mag) + d;
        if (target > 32767)
            target = int'(board.prev_mag) - d;
        if (target < 0 || target > 32767)
            target = $urandom_range(32767);
        if ($urandom_range(1))
            target = -target;
        if ($urandom_range(1)) begin
            x = DATA_W'(target);
            y = '0;
        end
        else begin
            x = '0;
            y = DATA_W'(target);
        end
    endfunction

    // Random words; while a lockout runs, ticks dominate so it drains and
    // steps keep coming.
    task automatic run_words(input int count, input int sample_pct);
        logic                     op;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        for (int i = 0; i < count; i++) begin
            if (board.lockout_left != 0 && $urandom_range(3) != 0)
                op = OP_TICK;
            else
                op = ($urandom_range(99) < sample_pct) ? OP_SAMPLE : OP_TICK;
            x = DATA_W'($urandom);
            y = DATA_W'($urandom);
            if (op == OP_SAMPLE && $urandom_range(9) < 7)
                aim_sample(x, y);
            send_word(op, x, y);
        end
    endtask

    // Bring the block to idle: optionally tick out any lockout, drop valid,
    // wait for every owed result, then give the pipeline a few spare cycles.
    task automatic settle(input bit drain_lockout);
        while (drain_lockout && board.lockout_left != 0)
            send_word(OP_TICK, DATA_W'($urandom), DATA_W'($urandom));
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // cfg_valid stays up across consecutive writes; the caller lowers it.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge clk); while (!cfg_ready);
        board.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_window(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                              input logic [DATA_W-1:0] lock);
        write_reg(CFG_LOW_THRESHOLD, lo);
        write_reg(CFG_HIGH_THRESHOLD, hi);
        write_reg(CFG_LOCKOUT_TICKS, lock);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus one long hold-off counted here.
    // ------------------------------------------------------------------------
    initial
    begin : collect_results
        int  calm;
        int  stall;
        int  got;
        bit  held;
        calm = 0;
        got  = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = pick_gap(calm);
            if (!held && got == HOLD_AFTER_RESULTS) begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(negedge clk); while (!out_valid);
            board.check_result('{step_seen, sample_ignored, magnitude, total_steps});
            got++;
            @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : run_test
        int lo;
        int wait_cycles;
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset thresholds 64 / 769, lockout 200. Walk the strict window
        // edges, then hit a step and probe the lockout with extreme samples.
        send_word(OP_SAMPLE, 0, 0);                 // no change
        send_word(OP_SAMPLE, 64, 0);                // delta on low edge: no step
        send_word(OP_SAMPLE, 0, -833);              // delta on high edge: no step
        send_word(OP_SAMPLE, -65, 0);               // delta 768: step, lockout starts
        send_word(OP_SAMPLE, -32768, -32768);       // dropped, largest root
        send_word(OP_SAMPLE, 32767, 32767);         // dropped
        send_word(OP_TICK, -32768, 32767);
        send_word(OP_SAMPLE, 0, -32768);            // dropped
        send_word(OP_SAMPLE, -1, 0);                // dropped
        send_word(OP_TICK, 32767, -1);

        // Reset settings under random traffic; the long lockout drains via ticks.
        run_words(220, 60);
        settle(1'b1);

        // Widest window, no lockout: nearly every sample steps.
        // The unused index must not disturb anything.
        write_reg(CFG_UNUSED_INDEX, 16'h0001);
        set_window(16'h0000, 16'hFFFF, 16'h0000);
        send_word(OP_TICK, 0, 0);                   // tick with no lockout
        run_words(340, 98);
        settle(1'b1);

        // Reset-like window with a short lockout.
        set_window(16'd64, 16'd769, 16'd3);
        run_words(120, 70);
        settle(1'b1);

        // Window with room for a single delta, then two shut windows.
        set_window(16'd300, 16'd302, 16'd2);
        run_words(30, 80);
        settle(1'b1);
        set_window(16'd500, 16'd501, 16'd1);
        run_words(30, 80);
        settle(1'b1);
        set_window(16'hFFFF, 16'h0000, 16'd5);
        run_words(30, 80);
        settle(1'b1);

        // A few random settings.
        for (int p = 0; p < 3; p++) begin
            lo = $urandom_range(400);
            set_window(DATA_W'(lo), DATA_W'(lo + $urandom_range(1500, 2)),
                       DATA_W'($urandom_range(12)));
            run_words(60, 70);
            settle(1'b1);
        end

        // Longest lockout: one step, then samples are dropped from there on.
        set_window(16'h0000, 16'hFFFF, 16'hFFFF);
        run_words(30, 60);
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 20000) begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);

        $display("Covered %0d samples and %0d ticks: %0d steps (%0d at saturation), %0d dropped.",
                 board.n_samples, board.n_ticks, board.n_steps, board.n_saturated,
                 board.n_dropped);
        $display("Register settings included reset values, open, shut and random windows.");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("accel_magnitude_step_counter_top test passed");
        else
            $display("accel_magnitude_step_counter_top test failed");
        $finish;
    end
endmodule

[accel_magnitude_step_counter_top.f]
rtl/amsc_pkg.sv
rtl/accel_magnitude_step_counter_top.sv
rtl/amsc_checker.sv
bench/testbench.sv
